// ===== rtl/vpu_pkg.sv =====
// Shared types, constants and helpers for the Verlet particle update block.
// Used by vpu_wrap, vpu_ctrl, vpu_datapath and verlet_particle_update.
// No dependencies.
package vpu_pkg;

    localparam int AXES      = 3;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_SIZE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP_SQ  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_INV_STEP = 2'd3;

    localparam logic [30:0] BOX_SIZE_RST      = 31'd655360;
    localparam logic [31:0] TIME_STEP_RST     = 32'd4294967;
    localparam logic [31:0] TIME_STEP_SQ_RST  = 32'd4295;
    localparam logic [30:0] HALF_INV_STEP_RST = 31'd32768000;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // remainder unit: bits retired per cycle
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES         = WORD_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_SUM,
        ST_MUL2,
        ST_VEL,
        ST_MUL3,
        ST_KE,
        ST_WAIT,
        ST_COMMIT
    } vpu_state_t;

    typedef enum logic [1:0] {
        MUL_DT,
        MUL_DT_SQ,
        MUL_HINV,
        MUL_SQUARE
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        logic     cap_sum;
        logic     div_start;
        logic     cap_vel;
        logic     cap_ke;
        logic     commit;
    } vpu_cmd_t;

    typedef struct packed {
        logic is_step;
        logic div_done;
        logic out_free;
    } vpu_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -50'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ===== rtl/vpu_wrap.sv =====
// Periodic wrap unit: floor remainder of a signed word by the box size,
// restoring division, DIV_BITS_PER_CYCLE bits per cycle. Depends on vpu_pkg.
module vpu_wrap (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [31:0]  dividend,
    input  logic        [30:0]  divisor,
    output logic                busy,
    output logic        [30:0]  remainder
);
    import vpu_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [31:0]          dvd_reg, dvd_next;
    logic [30:0]          rem_reg, rem_next;
    logic [31:0]          trial;
    logic [30:0]          r_step;
    logic [31:0]          d_step;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        r_step    = rem_reg;
        d_step    = dvd_reg;
        trial     = '0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[31];
            dvd_next  = dividend[31] ? 32'(-dividend) : 32'(dividend);
            rem_next  = '0;
        end else if (busy_reg) begin
            for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
                trial  = {r_step, d_step[31]};
                d_step = {d_step[30:0], 1'b0};
                if (trial >= {1'b0, divisor}) begin
                    r_step = 31'(trial - {1'b0, divisor});
                end else begin
                    r_step = trial[30:0];
                end
            end
            rem_next = r_step;
            dvd_next = d_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    // negative side: a true ceiling, so a zero remainder stays zero
    assign remainder = (neg_reg && rem_reg != '0) ? 31'(divisor - rem_reg) : rem_reg;

endmodule

// ===== rtl/vpu_ctrl.sv =====
// Sequencer for the Verlet particle update: steps one item through the
// datapath by command beats. Depends on vpu_pkg.
module vpu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output vpu_pkg::vpu_cmd_t cmd,
    input  vpu_pkg::vpu_sts_t sts
);
    import vpu_pkg::*;

    vpu_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_DT;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd.mul_sel = sts.is_step ? MUL_DT_SQ : MUL_DT;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                cmd.cap_sum = 1'b1;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_sel   = MUL_HINV;
                cmd.div_start = sts.is_step;
                state_next    = ST_VEL;
            end
            ST_VEL: begin
                cmd.cap_vel = 1'b1;
                state_next  = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul_sel = MUL_SQUARE;
                state_next  = ST_KE;
            end
            ST_KE: begin
                cmd.cap_ke = 1'b1;
                state_next = sts.is_step ? ST_WAIT : ST_COMMIT;
            end
            ST_WAIT: begin
                if (sts.div_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/vpu_datapath.sv =====
// Datapath: particle position memories, per-axis multipliers, wrap units,
// configuration registers and the output register. Depends on vpu_pkg, vpu_wrap.
module vpu_datapath #(
    parameter int PARTICLES = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [vpu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               s_opcode,
    input  logic [7:0]                         s_particle,
    input  logic signed [31:0]                 s_load_x,
    input  logic signed [31:0]                 s_load_y,
    input  logic signed [31:0]                 s_load_z,
    input  logic signed [31:0]                 s_load_vx,
    input  logic signed [31:0]                 s_load_vy,
    input  logic signed [31:0]                 s_load_vz,
    input  logic signed [31:0]                 s_accel_x,
    input  logic signed [31:0]                 s_accel_y,
    input  logic signed [31:0]                 s_accel_z,
    input  vpu_pkg::vpu_cmd_t                  cmd,
    output vpu_pkg::vpu_sts_t                  sts,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_out_particle,
    output logic signed [31:0]                 m_out_x,
    output logic signed [31:0]                 m_out_y,
    output logic signed [31:0]                 m_out_z,
    output logic signed [31:0]                 m_out_vx,
    output logic signed [31:0]                 m_out_vy,
    output logic signed [31:0]                 m_out_vz,
    output logic [31:0]                        m_kinetic_energy
);
    import vpu_pkg::*;

    localparam int DEPTH = (PARTICLES > 256) ? 256 : PARTICLES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration
    logic [30:0] box_size_reg;
    logic [31:0] time_step_reg;
    logic [31:0] time_step_sq_reg;
    logic [30:0] half_inv_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_size_reg      <= BOX_SIZE_RST;
            time_step_reg     <= TIME_STEP_RST;
            time_step_sq_reg  <= TIME_STEP_SQ_RST;
            half_inv_step_reg <= HALF_INV_STEP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BOX_SIZE:      box_size_reg      <= cfg_data[30:0];
                CFG_TIME_STEP:     time_step_reg     <= cfg_data;
                CFG_TIME_STEP_SQ:  time_step_sq_reg  <= cfg_data;
                CFG_HALF_INV_STEP: half_inv_step_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // item registers
    logic          op_reg;
    logic [7:0]    particle_reg;
    logic          in_range_reg;
    logic signed [31:0] s_pos [AXES];
    logic signed [31:0] s_vel [AXES];
    logic signed [31:0] s_acc [AXES];

    assign s_pos[0] = s_load_x;
    assign s_pos[1] = s_load_y;
    assign s_pos[2] = s_load_z;
    assign s_vel[0] = s_load_vx;
    assign s_vel[1] = s_load_vy;
    assign s_vel[2] = s_load_vz;
    assign s_acc[0] = s_accel_x;
    assign s_acc[1] = s_accel_y;
    assign s_acc[2] = s_accel_z;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg       <= s_opcode;
            particle_reg <= s_particle;
            in_range_reg <= (32'(s_particle) < 32'(PARTICLES));
        end
    end

    // position memories: x in the low word, z in the high word
    logic [AXES*32-1:0] cur_mem  [DEPTH];
    logic [AXES*32-1:0] prev_mem [DEPTH];
    logic [AXES*32-1:0] rd_cur_reg;
    logic [AXES*32-1:0] rd_prev_reg;
    logic [AXES*32-1:0] wr_cur;
    logic [AXES*32-1:0] wr_prev;
    logic               mem_we;

    assign mem_we = cmd.commit && in_range_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cur_mem[particle_reg[AW-1:0]]  <= wr_cur;
            prev_mem[particle_reg[AW-1:0]] <= wr_prev;
        end
        if (cmd.load_in) begin
            rd_cur_reg  <= cur_mem[s_particle[AW-1:0]];
            rd_prev_reg <= prev_mem[s_particle[AW-1:0]];
        end
    end

    // per-axis arithmetic
    logic signed [31:0] ld_pos_reg [AXES];
    logic signed [31:0] ld_vel_reg [AXES];
    logic signed [31:0] acc_reg    [AXES];
    logic signed [31:0] sum_reg    [AXES];
    logic signed [31:0] vel_reg    [AXES];
    logic signed [65:0] prod_reg   [AXES];
    logic signed [32:0] mul_a      [AXES];
    logic signed [32:0] mul_b      [AXES];
    logic signed [31:0] cur_p      [AXES];
    logic signed [31:0] prev_q     [AXES];
    logic signed [31:0] prod_hi    [AXES];
    logic signed [31:0] sum_next   [AXES];
    logic signed [31:0] cur_new    [AXES];
    logic signed [31:0] prev_new   [AXES];
    logic        [30:0] wrap_rem   [AXES];
    logic        [AXES-1:0] wrap_busy;

    for (genvar k = 0; k < AXES; k++) begin : g_axis
        assign cur_p[k]   = rd_cur_reg[32*k +: 32];
        assign prev_q[k]  = rd_prev_reg[32*k +: 32];
        assign prod_hi[k] = prod_reg[k][63:32];

        always_comb begin
            case (cmd.mul_sel)
                MUL_DT: begin
                    mul_a[k] = 33'(ld_vel_reg[k]);
                    mul_b[k] = $signed({1'b0, time_step_reg});
                end
                MUL_DT_SQ: begin
                    mul_a[k] = 33'(acc_reg[k]);
                    mul_b[k] = $signed({1'b0, time_step_sq_reg});
                end
                MUL_HINV: begin
                    mul_a[k] = 33'(sum_reg[k]) - 33'(prev_q[k]);
                    mul_b[k] = $signed({2'b00, half_inv_step_reg});
                end
                MUL_SQUARE: begin
                    mul_a[k] = 33'(vel_reg[k]);
                    mul_b[k] = 33'(vel_reg[k]);
                end
                default: begin
                    mul_a[k] = '0;
                    mul_b[k] = '0;
                end
            endcase
        end

        // load: previous = pos - v*dt; step: new = 2*pos - prev + a*dt^2
        assign sum_next[k] = (op_reg == OP_STEP)
            ? sat32(50'(cur_p[k]) + 50'(cur_p[k]) - 50'(prev_q[k]) + 50'(prod_hi[k]))
            : sat32(50'(ld_pos_reg[k]) - 50'(prod_hi[k]));

        always_ff @(posedge aclk) begin
            prod_reg[k] <= mul_a[k] * mul_b[k];
            if (cmd.load_in) begin
                ld_pos_reg[k] <= s_pos[k];
                ld_vel_reg[k] <= s_vel[k];
                acc_reg[k]    <= s_acc[k];
            end
            if (cmd.cap_sum) begin
                sum_reg[k] <= sum_next[k];
            end
            if (cmd.cap_vel) begin
                vel_reg[k] <= (op_reg == OP_STEP) ? sat32(prod_reg[k][65:16])
                                                  : ld_vel_reg[k];
            end
        end

        vpu_wrap u_wrap (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .start     (cmd.div_start),
            .dividend  (sum_reg[k]),
            .divisor   (box_size_reg),
            .busy      (wrap_busy[k]),
            .remainder (wrap_rem[k])
        );

        // a zero box leaves the position unwrapped; previous moves by the same shift
        always_comb begin
            if (op_reg == OP_STEP) begin
                cur_new[k]  = (box_size_reg == '0) ? sum_reg[k] : $signed({1'b0, wrap_rem[k]});
                prev_new[k] = sat32(50'(cur_p[k]) + 50'(cur_new[k]) - 50'(sum_reg[k]));
            end else begin
                cur_new[k]  = ld_pos_reg[k];
                prev_new[k] = sum_reg[k];
            end
        end

        assign wr_cur[32*k +: 32]  = cur_new[k];
        assign wr_prev[32*k +: 32] = prev_new[k];
    end

    // kinetic energy: sum of squares >> 17, saturated
    logic [63:0] sq_sum;
    logic [31:0] ke_reg;

    assign sq_sum = prod_reg[0][63:0] + prod_reg[1][63:0] + prod_reg[2][63:0];

    always_ff @(posedge aclk) begin
        if (cmd.cap_ke) begin
            ke_reg <= (|sq_sum[63:49]) ? 32'hffff_ffff : sq_sum[48:17];
        end
    end

    // output register
    logic               m_valid_reg;
    logic [7:0]         m_particle_reg;
    logic signed [31:0] m_pos_reg [AXES];
    logic signed [31:0] m_vel_reg [AXES];
    logic [31:0]        m_ke_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_particle_reg <= particle_reg;
            m_ke_reg       <= in_range_reg ? ke_reg : '0;
            for (int k = 0; k < AXES; k++) begin
                m_pos_reg[k] <= in_range_reg ? cur_new[k] : '0;
                m_vel_reg[k] <= in_range_reg ? vel_reg[k] : '0;
            end
        end
    end

    assign sts.is_step  = (op_reg == OP_STEP);
    assign sts.div_done = ~|wrap_busy;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_out_particle   = m_particle_reg;
    assign m_out_x          = m_pos_reg[0];
    assign m_out_y          = m_pos_reg[1];
    assign m_out_z          = m_pos_reg[2];
    assign m_out_vx         = m_vel_reg[0];
    assign m_out_vy         = m_vel_reg[1];
    assign m_out_vz         = m_vel_reg[2];
    assign m_kinetic_energy = m_ke_reg;

endmodule

// ===== rtl/verlet_particle_update.sv =====
// Verlet particle update: position Verlet integrator with periodic box, Q16.16.
// Top level; joins vpu_ctrl and vpu_datapath. Depends on vpu_pkg.
//
// Use:
//   Input channel s_*: one beat is a load (opcode 0: store position, derive
//   previous from velocity*dt) or a step (opcode 1: integrate one particle).
//   Output channel m_*: one beat per input beat, in order, carrying the new
//   position, velocity and kinetic energy of that particle.
//   cfg_*: plain register writes, only while no item is in flight.
// Timing:
//   One item at a time: the next item is accepted only after the last commits.
//   A step waits in the wait state for the wrap remainder unit, which retires
//   2 bits a cycle and sets the step time. Memory and result register are
//   written at the same edge, in the commit state.
// Reset (aresetn low, synchronous): controller idle, output empty, config
//   registers at their defaults. Position memory is not cleared.
// Stall: a finished result waits in the output register; the next item is
//   accepted meanwhile and holds in its final cycle until the register frees.
module verlet_particle_update #(
    parameter int PARTICLES = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [vpu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic [7:0]                         s_particle,
    input  logic signed [31:0]                 s_load_x,
    input  logic signed [31:0]                 s_load_y,
    input  logic signed [31:0]                 s_load_z,
    input  logic signed [31:0]                 s_load_vx,
    input  logic signed [31:0]                 s_load_vy,
    input  logic signed [31:0]                 s_load_vz,
    input  logic signed [31:0]                 s_accel_x,
    input  logic signed [31:0]                 s_accel_y,
    input  logic signed [31:0]                 s_accel_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_out_particle,
    output logic signed [31:0]                 m_out_x,
    output logic signed [31:0]                 m_out_y,
    output logic signed [31:0]                 m_out_z,
    output logic signed [31:0]                 m_out_vx,
    output logic signed [31:0]                 m_out_vy,
    output logic signed [31:0]                 m_out_vz,
    output logic [31:0]                        m_kinetic_energy
);
    import vpu_pkg::*;

    vpu_cmd_t cmd;
    vpu_sts_t sts;

    vpu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    vpu_datapath #(
        .PARTICLES (PARTICLES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_opcode         (s_opcode),
        .s_particle       (s_particle),
        .s_load_x         (s_load_x),
        .s_load_y         (s_load_y),
        .s_load_z         (s_load_z),
        .s_load_vx        (s_load_vx),
        .s_load_vy        (s_load_vy),
        .s_load_vz        (s_load_vz),
        .s_accel_x        (s_accel_x),
        .s_accel_y        (s_accel_y),
        .s_accel_z        (s_accel_z),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_particle   (m_out_particle),
        .m_out_x          (m_out_x),
        .m_out_y          (m_out_y),
        .m_out_z          (m_out_z),
        .m_out_vx         (m_out_vx),
        .m_out_vy         (m_out_vy),
        .m_out_vz         (m_out_vz),
        .m_kinetic_energy (m_kinetic_energy)
    );

`ifndef SYNTHESIS
    // a result is only written into a free output register
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> sts.out_free)
        else $error("commit while output register held");

    // the wrap units are never restarted mid-division
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> sts.div_done)
        else $error("wrap unit restarted while busy");

    // one item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // the output only becomes valid from a commit
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.commit))
        else $error("output valid without commit");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for verlet_particle_update: load and step beats are driven through
// valid/ready, results predicted by a behavioural integrator and checked in order.
// Depends on vpu_pkg and the verlet_particle_update RTL.
module testbench;
    import vpu_pkg::*;

    localparam int NUM_PARTICLES   = 256;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 32;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_GAP         = 50;
    localparam int PHASE_BEATS     = 440;

    typedef struct packed {
        logic             opcode;
        logic [7:0]       particle;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] accel;
    } particle_beat_t;

    typedef struct packed {
        logic [7:0]       particle;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [31:0]      energy;
    } motion_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    particle_beat_t       s_beat    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [7:0]           m_out_particle;
    logic signed [31:0]   m_out_x, m_out_y, m_out_z;
    logic signed [31:0]   m_out_vx, m_out_vy, m_out_vz;
    logic [31:0]          m_kinetic_energy;

    // shadow copy of the configuration registers
    logic [30:0] box_size      = BOX_SIZE_RST;
    logic [31:0] time_step     = TIME_STEP_RST;
    logic [31:0] time_step_sq  = TIME_STEP_SQ_RST;
    logic [30:0] half_inv_step = HALF_INV_STEP_RST;

    // shadow particle store
    logic [2:0][31:0] cur_store  [NUM_PARTICLES];
    logic [2:0][31:0] prev_store [NUM_PARTICLES];
    bit               loaded     [NUM_PARTICLES];

    motion_t expected_motion [$];
    int      error_count    = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      hold_len       = 0;
    int      hold_seq       = 0;

    verlet_particle_update #(.PARTICLES(NUM_PARTICLES)) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_beat.opcode),
        .s_particle       (s_beat.particle),
        .s_load_x         (s_beat.pos[0]),
        .s_load_y         (s_beat.pos[1]),
        .s_load_z         (s_beat.pos[2]),
        .s_load_vx        (s_beat.vel[0]),
        .s_load_vy        (s_beat.vel[1]),
        .s_load_vz        (s_beat.vel[2]),
        .s_accel_x        (s_beat.accel[0]),
        .s_accel_y        (s_beat.accel[1]),
        .s_accel_z        (s_beat.accel[2]),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_particle   (m_out_particle),
        .m_out_x          (m_out_x),
        .m_out_y          (m_out_y),
        .m_out_z          (m_out_z),
        .m_out_vx         (m_out_vx),
        .m_out_vy         (m_out_vy),
        .m_out_vz         (m_out_vz),
        .m_kinetic_energy (m_kinetic_energy)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_motion.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [31:0] clamp_word(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] half_speed_sq(input logic [2:0][31:0] vel);
        longint unsigned sum;
        longint          s;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            s = longint'(signed'(vel[k]));
            sum += s * s;
        end
        sum = sum >> 17;
        return (sum > 64'hffffffff) ? 32'hffffffff : sum[31:0];
    endfunction

    // advances the shadow store by one beat and returns the result it gives
    function automatic motion_t integrate(input particle_beat_t b);
        motion_t r;
        longint  p, q, a, vv, nw, box, shift;
        int      idx;
        idx        = int'(b.particle);
        r          = '0;
        r.particle = b.particle;
        box        = longint'(box_size);
        if (b.opcode == OP_LOAD) begin
            for (int k = 0; k < 3; k++) begin
                p  = longint'(signed'(b.pos[k]));
                vv = longint'(signed'(b.vel[k]));
                cur_store[idx][k]  = b.pos[k];
                prev_store[idx][k] = clamp_word(p - ((vv * longint'(time_step)) >>> 32));
                r.vel[k] = b.vel[k];
            end
            loaded[idx] = 1'b1;
        end else begin
            for (int k = 0; k < 3; k++) begin
                p  = longint'(signed'(cur_store[idx][k]));
                q  = longint'(signed'(prev_store[idx][k]));
                a  = longint'(signed'(b.accel[k]));
                nw = longint'(signed'(clamp_word(2 * p - q
                                     + ((a * longint'(time_step_sq)) >>> 32))));
                r.vel[k] = clamp_word(((nw - q) * longint'(half_inv_step)) >>> 16);
                shift = 0;
                // zero box: no wrap; negative side uses a true ceiling
                if (box > 0) begin
                    if (nw < 0) begin
                        shift = ((-nw + box - 1) / box) * box;
                    end else if (nw >= box) begin
                        shift = -((nw / box) * box);
                    end
                end
                cur_store[idx][k]  = clamp_word(nw + shift);
                prev_store[idx][k] = clamp_word(p + shift);
            end
        end
        for (int k = 0; k < 3; k++) begin
            r.pos[k] = cur_store[idx][k];
        end
        r.energy = half_speed_sq(r.vel);
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        motion_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_motion.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual particle %0d",
                         $time, m_out_particle);
                error_count++;
            end else begin
                want = expected_motion.pop_front();
                check_field("out_particle", 32'(want.particle), 32'(m_out_particle));
                check_field("out_x", want.pos[0], m_out_x);
                check_field("out_y", want.pos[1], m_out_y);
                check_field("out_z", want.pos[2], m_out_z);
                check_field("out_vx", want.vel[0], m_out_vx);
                check_field("out_vy", want.vel[1], m_out_vy);
                check_field("out_vz", want.vel[2], m_out_vz);
                check_field("kinetic_energy", want.energy, m_kinetic_energy);
            end
        end
    end

    // result side: random stalls, plus long hold-offs on request
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------- driving

    task automatic send_beat(input particle_beat_t b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < MAX_GAP) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_beat  <= b;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_motion.push_back(integrate(b));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_motion.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // leaves the write enable high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [31:0] box, input logic [31:0] dt,
                              input logic [31:0] dt_sq, input logic [31:0] hinv);
        write_reg(CFG_BOX_SIZE, box);
        write_reg(CFG_TIME_STEP, dt);
        write_reg(CFG_TIME_STEP_SQ, dt_sq);
        write_reg(CFG_HALF_INV_STEP, hinv);
        cfg_wr_en     <= 1'b0;
        box_size      = box[30:0];
        time_step     = dt;
        time_step_sq  = dt_sq;
        half_inv_step = hinv[30:0];
    endtask

    function automatic particle_beat_t make_beat(input logic op, input logic [7:0] idx,
                                                 input logic [31:0] p, input logic [31:0] v,
                                                 input logic [31:0] a);
        particle_beat_t b;
        b.opcode   = op;
        b.particle = idx;
        for (int k = 0; k < 3; k++) begin
            b.pos[k]   = p;
            b.vel[k]   = v;
            b.accel[k] = a;
        end
        return b;
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        case ($urandom_range(7))
            0, 1: w = $urandom;
            2: begin
                case ($urandom_range(3))
                    0:       w = 32'h7fffffff;
                    1:       w = 32'h80000000;
                    2:       w = 32'h00000000;
                    default: w = 32'hffffffff;
                endcase
            end
            3, 4: begin
                // around the box, so that wraps happen on both sides
                w = $urandom_range({1'b0, box_size});
                if ($urandom_range(1)) w = -w;
            end
            default: begin
                w = $urandom_range(32'h0010_0000);
                if ($urandom_range(1)) w = -w;
            end
        endcase
        return w;
    endfunction

    // steps only hit particles already loaded; pool > 0 keeps to a few particles
    function automatic particle_beat_t random_beat(input int pool);
        particle_beat_t b;
        b.particle = (pool > 0) ? 8'($urandom_range(pool - 1))
                                : 8'($urandom_range(NUM_PARTICLES - 1));
        b.opcode   = ($urandom_range(99) < 70) ? OP_STEP : OP_LOAD;
        if (!loaded[b.particle]) begin
            b.opcode = OP_LOAD;
        end
        for (int k = 0; k < 3; k++) begin
            b.pos[k]   = random_word();
            b.vel[k]   = random_word();
            b.accel[k] = random_word();
        end
        return b;
    endfunction

    task automatic send_random(input int beats);
        for (int n = 0; n < beats; n++) begin
            send_beat(random_beat(($urandom_range(3) == 0) ? 0 : 8));
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_beat(make_beat(OP_LOAD, 8'd0, 32'h0, 32'h0, 32'h0));
        send_beat(make_beat(OP_STEP, 8'd0, 32'h0, 32'h0, 32'h0));
        // saturating energy, then new position saturating high
        send_beat(make_beat(OP_LOAD, 8'd255, 32'h7fffffff, 32'h7fffffff, 32'h0));
        send_beat(make_beat(OP_STEP, 8'd255, 32'h0, 32'h0, 32'h7fffffff));
        // previous position saturating low on load, new one low on step
        send_beat(make_beat(OP_LOAD, 8'd1, 32'h80000000, 32'h7fffffff, 32'hffffffff));
        send_beat(make_beat(OP_STEP, 8'd1, 32'hffffffff, 32'h80000000, 32'h80000000));
        // just below zero: wraps to the top of the box
        send_beat(make_beat(OP_LOAD, 8'd2, 32'hfffffffd, 32'h0, 32'h0));
        send_beat(make_beat(OP_STEP, 8'd2, 32'h0, 32'h0, 32'h0));
        // exactly one box either side of zero
        send_beat(make_beat(OP_LOAD, 8'd3, 32'd655360, 32'h0, 32'h0));
        send_beat(make_beat(OP_STEP, 8'd3, 32'h0, 32'h0, 32'h0));
        send_beat(make_beat(OP_LOAD, 8'd4, -32'd655360, 32'h0, 32'h0));
        send_beat(make_beat(OP_STEP, 8'd4, 32'h0, 32'h0, 32'h0));
        // same particle stepped back to back
        send_beat(make_beat(OP_LOAD, 8'd5, 32'd655359, 32'h80000000, 32'h0));
        send_beat(make_beat(OP_STEP, 8'd5, 32'h0, 32'h0, 32'h80000000));
        send_beat(make_beat(OP_STEP, 8'd5, 32'h0, 32'h0, 32'h80000000));
        send_beat(make_beat(OP_STEP, 8'd5, 32'h0, 32'h0, 32'h7fffffff));
        send_beat(make_beat(OP_LOAD, 8'd6, 32'h00050000, 32'h00010000, 32'h0));
        send_beat(make_beat(OP_STEP, 8'd6, 32'h0, 32'h0, 32'hfffe0000));
        send_beat(make_beat(OP_STEP, 8'd6, 32'h0, 32'h0, 32'hfffe0000));
        send_beat(make_beat(OP_LOAD, 8'd7, 32'hffffffff, 32'hffffffff, 32'h0));
        send_beat(make_beat(OP_STEP, 8'd7, 32'h0, 32'h0, 32'hffffffff));
        wait_idle();
    endtask

    task automatic test_config_corners();
        // top bit is dropped, so the box becomes zero: nothing wraps
        set_config(32'h80000000, TIME_STEP_RST, TIME_STEP_SQ_RST, {1'b0, HALF_INV_STEP_RST});
        send_beat(make_beat(OP_STEP, 8'd3, 32'h0, 32'h0, 32'h0));
        send_beat(make_beat(OP_STEP, 8'd4, 32'h0, 32'h0, 32'h0));
        send_beat(make_beat(OP_LOAD, 8'd8, 32'hfff00000, 32'h00200000, 32'h0));
        send_beat(make_beat(OP_STEP, 8'd8, 32'h0, 32'h0, 32'h80000000));
        send_beat(make_beat(OP_STEP, 8'd8, 32'h0, 32'h0, 32'h7fffffff));
        wait_idle();
        set_config(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_random(6);
        wait_idle();
        set_config(32'd1, 32'd1, 32'd1, 32'd1);
        send_random(6);
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config({1'b0, BOX_SIZE_RST}, TIME_STEP_RST, TIME_STEP_SQ_RST,
                   {1'b0, HALF_INV_STEP_RST});
        hold_len <= HOLD_OFF_CYCLES;
        hold_seq <= hold_seq + 1;
        send_random(12);
        wait_idle();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    set_config({1'b0, BOX_SIZE_RST}, TIME_STEP_RST, TIME_STEP_SQ_RST,
                               {1'b0, HALF_INV_STEP_RST});
                end
                1: begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 0;
                    set_config({1'($urandom_range(1)), 31'($urandom_range(1, 32'h0100_0000))},
                               $urandom, $urandom, $urandom);
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 52;
                    set_config({1'($urandom_range(1)), 31'($urandom_range(1, 32'h0004_0000))},
                               $urandom_range(1, 32'h0100_0000),
                               $urandom_range(1, 32'h0001_0000), $urandom);
                end
                default: begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                    set_config($urandom, $urandom, $urandom, $urandom);
                end
            endcase
            send_random(PHASE_BEATS);
            wait_idle();
        end
    endtask

    initial begin : main
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        test_config_corners();
        test_backpressure();
        test_random_phases();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
